>>> sv/lmtf_pkg.sv
`timescale 1ns / 1ps
// Package for the move-to-front recency list: sizes, request and status codes,
// sequencer states and the command bundle from the sequencer to the list store.
// No dependencies.
package lmtf_pkg;

  localparam int CAPACITY  = 64;
  localparam int PAGE_BITS = 52;
  localparam int PAGE_W    = 52;
  localparam int STATUS_W  = 3;
  localparam int HITPOS_W  = 6;
  localparam int OCC_W     = 7;
  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);

  typedef logic [PAGE_BITS-1:0] entry_t;
  typedef logic [IDX_W-1:0]     addr_t;
  typedef logic [CNT_W-1:0]     count_t;

  typedef enum logic {
    OP_TOUCH  = 1'b0,
    OP_REMOVE = 1'b1
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_HIT       = 3'd1,
    ST_REMOVED   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH_RD,
    S_SEARCH_CMP,
    S_MOVE_RD,
    S_MOVE_WR,
    S_RESULT
  } ctrl_state_t;

  typedef struct packed {
    logic  load_key;
    logic  rd_en;
    addr_t rd_addr;
    logic  wr_en;
    addr_t wr_addr;
    logic  wr_key;
  } store_cmd_t;

endpackage

>>> sv/lmtf_store.sv
`timescale 1ns / 1ps
// List store: the entry memory, the key register and the shared equality comparator.
// Depends on lmtf_pkg.
module lmtf_store import lmtf_pkg::*; (
  input  logic              clk,
  input  store_cmd_t        cmd,
  input  logic [PAGE_W-1:0] page_id,
  output logic              match
);

  entry_t mem [CAPACITY];
  entry_t key;
  entry_t rdata;

  always_ff @(posedge clk) begin
    if (cmd.load_key) begin
      key <= page_id[PAGE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.wr_addr] <= cmd.wr_key ? key : rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rdata <= mem[cmd.rd_addr];
    end
  end

  // One comparator serves every step of the search.
  assign match = (rdata == key);

endmodule

>>> sv/lmtf_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the recency list: walks the entries to search, then moves them
// one at a time to open or close a gap. Depends on lmtf_pkg.
module lmtf_ctrl import lmtf_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                opcode,
  input  logic                match,
  output store_cmd_t          cmd,
  output logic                busy,
  output logic                done,
  output logic [STATUS_W-1:0] status,
  output logic [HITPOS_W-1:0] hit_position,
  output logic [OCC_W-1:0]    occupancy
);

  ctrl_state_t state, state_next;
  opcode_t     op;
  count_t      idx;
  count_t      count;
  addr_t       pos;
  status_t     result;
  count_t      idx_inc;
  logic        accept;
  logic        at_end;
  logic        is_full;
  logic        last_move;

  assign accept    = start && (state == S_IDLE);
  assign idx_inc   = idx + count_t'(1);
  assign at_end    = (idx == count);
  assign is_full   = (count == count_t'(CAPACITY));
  assign last_move = (op == OP_REMOVE) ? (idx_inc >= count) : (idx == '0);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) state_next = S_SEARCH_RD;
      end
      S_SEARCH_RD: begin
        if (!at_end) begin
          state_next = S_SEARCH_CMP;
        end else if (op == OP_REMOVE || is_full) begin
          state_next = S_RESULT;
        end else begin
          state_next = S_MOVE_RD;
        end
      end
      S_SEARCH_CMP: begin
        state_next = match ? S_MOVE_RD : S_SEARCH_RD;
      end
      S_MOVE_RD: begin
        state_next = last_move ? S_RESULT : S_MOVE_WR;
      end
      S_MOVE_WR: state_next = S_MOVE_RD;
      S_RESULT:  state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.load_key = accept;
    cmd.wr_addr  = idx[IDX_W-1:0];
    case (state)
      S_SEARCH_RD: begin
        cmd.rd_en   = !at_end;
        cmd.rd_addr = idx[IDX_W-1:0];
      end
      S_MOVE_RD: begin
        if (op == OP_TOUCH && last_move) begin
          // The front slot takes the requested page.
          cmd.wr_en  = 1'b1;
          cmd.wr_key = 1'b1;
        end else if (!last_move) begin
          cmd.rd_en   = 1'b1;
          cmd.rd_addr = (op == OP_REMOVE) ? idx_inc[IDX_W-1:0]
                                          : addr_t'(idx - count_t'(1));
        end
      end
      S_MOVE_WR: begin
        cmd.wr_en = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          if (start) begin
            op     <= opcode_t'(opcode);
            idx    <= '0;
            pos    <= '0;
            result <= ST_NOT_FOUND;
          end
        end
        S_SEARCH_RD: begin
          if (at_end) begin
            if (op == OP_REMOVE) begin
              result <= ST_NOT_FOUND;
            end else if (is_full) begin
              result <= ST_FULL;
            end else begin
              // A miss opens a slot at the front by moving every entry back.
              result <= ST_INSERTED;
            end
          end
        end
        S_SEARCH_CMP: begin
          if (match) begin
            pos    <= idx[IDX_W-1:0];
            result <= (op == OP_REMOVE) ? ST_REMOVED : ST_HIT;
          end else begin
            idx <= idx_inc;
          end
        end
        S_MOVE_RD: begin
          if (last_move) begin
            if (op == OP_REMOVE) begin
              count <= count - count_t'(1);
            end else if (result == ST_INSERTED) begin
              count <= count + count_t'(1);
            end
          end
        end
        S_MOVE_WR: begin
          idx <= (op == OP_REMOVE) ? idx_inc : idx - count_t'(1);
        end
        default: ;
      endcase
    end
  end

  assign busy         = (state != S_IDLE);
  assign done         = (state == S_RESULT);
  assign status       = result;
  assign hit_position = HITPOS_W'(pos);
  assign occupancy    = OCC_W'(count);

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= count_t'(CAPACITY))
    else $error("occupancy above capacity");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy)
    else $error("result beat not followed by idle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not make the block busy");

  a_write_after_read: assert property (@(posedge clk) disable iff (rst)
    (state == S_MOVE_WR) |-> ($past(state) == S_MOVE_RD))
    else $error("entry move written without a preceding read");
`endif

endmodule

>>> sv/lru_move_to_front_list_unit.sv
`timescale 1ns / 1ps
// Move-to-front recency list of page numbers, most recent first.
// Depends on lmtf_pkg, lmtf_store and lmtf_ctrl.
//
// Usage: raise start with opcode and page_id while busy is low; the request is
// taken at that clock edge and busy stays high until the result has gone out.
// A touch (opcode 0) moves a found page to the front or, if the list has room,
// inserts a new one there; a remove (opcode 1) deletes the page and closes
// the gap behind it. Each request yields exactly one result beat: done is high
// for one cycle with status, hit_position and occupancy valid. The receiver
// cannot stall, so the beat is taken at the edge that ends that cycle.
// Search and move: the search reads one entry at a time through the memory's
// one read port and one comparator, and each entry move costs a read state and
// a write state. busy drops in the cycle after the result beat, when the next
// request can be taken.
// Reset (rst, synchronous) empties the list at once; the entries themselves are
// not cleared, since only those below the occupancy are ever read.
module lru_move_to_front_list_unit import lmtf_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                opcode,
  input  logic [PAGE_W-1:0]   page_id,
  output logic                busy,
  output logic                done,
  output logic [STATUS_W-1:0] status,
  output logic [HITPOS_W-1:0] hit_position,
  output logic [OCC_W-1:0]    occupancy
);

  store_cmd_t cmd;
  logic       match;

  lmtf_store u_store (
    .clk     (clk),
    .cmd     (cmd),
    .page_id (page_id),
    .match   (match)
  );

  lmtf_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .opcode       (opcode),
    .match        (match),
    .cmd          (cmd),
    .busy         (busy),
    .done         (done),
    .status       (status),
    .hit_position (hit_position),
    .occupancy    (occupancy)
  );

endmodule
